// ----- rtl/mse_pkg.sv -----
`timescale 1ns / 1ps

package mse_pkg;

  localparam int DATA_WORDS_DEF = 256;
  localparam int REG_COUNT      = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [5:0] OP_SPECIAL  = 6'd0;
  localparam logic [5:0] OP_REGIMM   = 6'd1;
  localparam logic [5:0] OP_J        = 6'd2;
  localparam logic [5:0] OP_ADDI     = 6'd8;
  localparam logic [5:0] OP_SPECIAL2 = 6'd28;
  localparam logic [5:0] OP_LW       = 6'd35;
  localparam logic [5:0] OP_SW       = 6'd43;

  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_MUL   = 6'd2;
  localparam logic [5:0] FN_JR    = 6'd8;
  localparam logic [5:0] FN_MOVZ  = 6'd10;
  localparam logic [5:0] FN_BREAK = 6'd13;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_SUB   = 6'd34;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_BREAK   = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_CONTROL = 3'd3,
    ST_WINDOW  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    CL_NONE    = 4'd0,
    CL_PRELOAD = 4'd1,
    CL_ADDI    = 4'd2,
    CL_ADD     = 4'd3,
    CL_SUB     = 4'd4,
    CL_MUL     = 4'd5,
    CL_MOVZ    = 4'd6,
    CL_SLL     = 4'd7,
    CL_SRL     = 4'd8,
    CL_LW      = 4'd9,
    CL_SW      = 4'd10
  } cls_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic [7:0]  preload_index;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               reg_written;
    logic [4:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_written;
    logic [7:0]         mem_index;
    logic signed [31:0] mem_value;
  } out_t;

  // Decoded transaction. For a preload, imm carries the data word.
  typedef struct packed {
    cls_t        cls;
    status_t     status;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dst;
    logic [4:0]  sh;
    logic [31:0] imm;
    logic [31:0] koff;
    logic [7:0]  pidx;
  } dec_t;

endpackage

// ----- rtl/mse_front.sv -----
`timescale 1ns / 1ps

module mse_front #(
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mse_pkg::in_t  in_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data,
  output logic          q_wr,
  output mse_pkg::dec_t q_wdata,
  input  logic          q_full
);

  logic [15:0] data_base_r;
  logic [5:0]  op;
  logic [5:0]  fn;
  logic [31:0] simm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      data_base_r <= cfg_data;
    end
  end

  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

  assign op   = in_data.word[31:26];
  assign fn   = in_data.word[5:0];
  assign simm = {{16{in_data.word[15]}}, in_data.word[15:0]};

  always_comb begin
    q_wdata        = '0;
    q_wdata.cls    = mse_pkg::CL_NONE;
    q_wdata.status = mse_pkg::ST_DONE;
    q_wdata.rs     = in_data.word[25:21];
    q_wdata.rt     = in_data.word[20:16];
    q_wdata.sh     = in_data.word[10:6];
    q_wdata.dst    = in_data.word[15:11];
    q_wdata.imm    = simm;
    q_wdata.koff   = simm - {16'd0, data_base_r};
    q_wdata.pidx   = in_data.preload_index;
    if (!in_data.kind) begin
      q_wdata.cls = mse_pkg::CL_PRELOAD;
      q_wdata.rs  = '0;
      q_wdata.rt  = '0;
      q_wdata.dst = '0;
      q_wdata.imm = in_data.word;
      if (32'(in_data.preload_index) >= 32'(DATA_WORDS)) begin
        q_wdata.status = mse_pkg::ST_WINDOW;
      end
    end else begin
      unique case (op) inside
        mse_pkg::OP_ADDI: begin
          q_wdata.cls = mse_pkg::CL_ADDI;
          q_wdata.dst = in_data.word[20:16];
        end
        mse_pkg::OP_LW: begin
          q_wdata.cls = mse_pkg::CL_LW;
          q_wdata.dst = in_data.word[20:16];
        end
        mse_pkg::OP_SW: begin
          q_wdata.cls = mse_pkg::CL_SW;
        end
        mse_pkg::OP_REGIMM, mse_pkg::OP_J: begin
          q_wdata.status = mse_pkg::ST_CONTROL;
        end
        mse_pkg::OP_SPECIAL2: begin
          if (fn == mse_pkg::FN_MUL) begin
            q_wdata.cls = mse_pkg::CL_MUL;
          end else begin
            q_wdata.status = mse_pkg::ST_UNKNOWN;
          end
        end
        mse_pkg::OP_SPECIAL: begin
          unique case (fn)
            mse_pkg::FN_SLL:   q_wdata.cls = mse_pkg::CL_SLL;
            mse_pkg::FN_SRL:   q_wdata.cls = mse_pkg::CL_SRL;
            mse_pkg::FN_SUB:   q_wdata.cls = mse_pkg::CL_SUB;
            mse_pkg::FN_ADD:   q_wdata.cls = mse_pkg::CL_ADD;
            mse_pkg::FN_MOVZ:  q_wdata.cls = mse_pkg::CL_MOVZ;
            mse_pkg::FN_BREAK: q_wdata.status = mse_pkg::ST_BREAK;
            mse_pkg::FN_JR:    q_wdata.status = mse_pkg::ST_CONTROL;
            default:           q_wdata.status = mse_pkg::ST_UNKNOWN;
          endcase
        end
        default: begin
          q_wdata.status = mse_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// ----- rtl/mse_queue.sv -----
`timescale 1ns / 1ps

module mse_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  mse_pkg::dec_t wdata,
  output logic          full,
  input  logic          rd,
  output mse_pkg::dec_t rdata,
  output logic          empty
);

  localparam int PW = $clog2(mse_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mse_pkg::QUEUE_DEPTH + 1);

  mse_pkg::dec_t mem_r [mse_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(mse_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) begin
        wptr_r <= wptr_r + PW'(1);
      end
      if (rd) begin
        rptr_r <= rptr_r + PW'(1);
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/mse_back.sv -----
`timescale 1ns / 1ps

module mse_back #(
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  output logic          q_rd,
  input  mse_pkg::dec_t q_rdata,
  output logic          out_valid,
  input  logic          out_stall,
  output mse_pkg::out_t out_data
);

  localparam int AW = $clog2(DATA_WORDS);

  typedef enum logic [1:0] {
    SEL_ALU = 2'd0,
    SEL_MUL = 2'd1,
    SEL_MEM = 2'd2
  } sel_t;

  logic                         adv;

  logic [31:0]                  rf_mem [mse_pkg::REG_COUNT];
  logic [mse_pkg::REG_COUNT-1:0] rf_vld_r;
  logic [31:0]                  dmem [DATA_WORDS];

  logic                         s2_vld_r;
  mse_pkg::dec_t                s2_dec_r;
  logic [31:0]                  rf_a_r;
  logic [31:0]                  rf_b_r;
  logic                         a_vld_r;
  logic                         b_vld_r;

  logic                         s3_vld_r;
  logic [2:0]                   s3_status_r;
  logic                         s3_rw_r;
  logic [4:0]                   s3_dst_r;
  sel_t                         s3_sel_r;
  logic [31:0]                  s3_alu_r;
  logic [31:0]                  s3_mul_r;
  logic                         s3_mw_r;
  logic [7:0]                   s3_midx_r;
  logic [31:0]                  s3_mval_r;
  logic [31:0]                  dmem_q_r;
  logic [31:0]                  s3_val;

  logic                         w_vld_r;
  logic [4:0]                   w_idx_r;
  logic [31:0]                  w_val_r;

  logic                         out_valid_r;
  mse_pkg::out_t                out_data_r;

  logic [31:0]                  opa;
  logic [31:0]                  opb;
  logic [31:0]                  alu;
  logic [31:0]                  off;
  logic                         in_win;
  logic [AW-1:0]                widx;
  logic                         rw_nxt;
  logic [2:0]                   status_nxt;
  logic                         mw_nxt;
  sel_t                         sel_nxt;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  logic [31:0]                  mem_wd;

  assign adv  = !out_valid_r || !out_stall;
  assign q_rd = adv && !q_empty;

  always_comb begin
    unique case (s3_sel_r)
      SEL_MUL: s3_val = s3_mul_r;
      SEL_MEM: s3_val = dmem_q_r;
      default: s3_val = s3_alu_r;
    endcase
  end

  // Operand bypass: the transaction one stage ahead, then the last file write.
  always_comb begin
    if (s3_vld_r && s3_rw_r && s3_dst_r == s2_dec_r.rs) begin
      opa = s3_val;
    end else if (w_vld_r && w_idx_r == s2_dec_r.rs) begin
      opa = w_val_r;
    end else begin
      opa = a_vld_r ? rf_a_r : '0;
    end
    if (s3_vld_r && s3_rw_r && s3_dst_r == s2_dec_r.rt) begin
      opb = s3_val;
    end else if (w_vld_r && w_idx_r == s2_dec_r.rt) begin
      opb = w_val_r;
    end else begin
      opb = b_vld_r ? rf_b_r : '0;
    end
  end

  assign off    = opa + s2_dec_r.koff;
  assign in_win = (off[1:0] == 2'b00) && ((off >> 2) < 32'(DATA_WORDS));
  assign widx   = off[AW+1:2];

  always_comb begin
    alu        = '0;
    rw_nxt     = 1'b0;
    mw_nxt     = 1'b0;
    sel_nxt    = SEL_ALU;
    status_nxt = s2_dec_r.status;
    case (s2_dec_r.cls)
      mse_pkg::CL_ADDI: begin
        alu    = opa + s2_dec_r.imm;
        rw_nxt = 1'b1;
      end
      mse_pkg::CL_ADD: begin
        alu    = opa + opb;
        rw_nxt = 1'b1;
      end
      mse_pkg::CL_SUB: begin
        alu    = opa - opb;
        rw_nxt = 1'b1;
      end
      mse_pkg::CL_MOVZ: begin
        alu    = opa;
        rw_nxt = (opb == '0);
      end
      mse_pkg::CL_SLL: begin
        alu    = opb << s2_dec_r.sh;
        rw_nxt = 1'b1;
      end
      mse_pkg::CL_SRL: begin
        alu    = opb >> s2_dec_r.sh;
        rw_nxt = 1'b1;
      end
      mse_pkg::CL_MUL: begin
        sel_nxt = SEL_MUL;
        rw_nxt  = 1'b1;
      end
      mse_pkg::CL_LW: begin
        sel_nxt = SEL_MEM;
        rw_nxt  = in_win;
        if (!in_win) begin
          status_nxt = mse_pkg::ST_WINDOW;
        end
      end
      mse_pkg::CL_SW: begin
        mw_nxt = in_win;
        if (!in_win) begin
          status_nxt = mse_pkg::ST_WINDOW;
        end
      end
      default: begin
        alu = '0;
      end
    endcase
    if (s2_dec_r.dst == '0) begin
      rw_nxt = 1'b0;
    end
  end

  always_comb begin
    if (s2_dec_r.cls == mse_pkg::CL_PRELOAD) begin
      mem_we = (s2_dec_r.status == mse_pkg::ST_DONE);
      mem_wa = AW'(s2_dec_r.pidx);
      mem_wd = s2_dec_r.imm;
    end else begin
      mem_we = mw_nxt;
      mem_wa = widx;
      mem_wd = opb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r && mem_we) begin
      dmem[mem_wa] <= mem_wd;
    end
    if (adv) begin
      dmem_q_r <= dmem[widx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_vld_r && s3_rw_r) begin
      rf_mem[s3_dst_r] <= s3_val;
    end
    if (adv) begin
      rf_a_r  <= rf_mem[q_rdata.rs];
      rf_b_r  <= rf_mem[q_rdata.rt];
      a_vld_r <= rf_vld_r[q_rdata.rs];
      b_vld_r <= rf_vld_r[q_rdata.rt];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dec_r    <= q_rdata;
      s3_status_r <= status_nxt;
      s3_rw_r     <= rw_nxt;
      s3_dst_r    <= s2_dec_r.dst;
      s3_sel_r    <= sel_nxt;
      s3_alu_r    <= alu;
      s3_mul_r    <= opa * opb;
      s3_mw_r     <= mw_nxt;
      s3_midx_r   <= mw_nxt ? off[9:2] : 8'd0;
      s3_mval_r   <= mw_nxt ? opb : 32'd0;
      w_idx_r     <= s3_dst_r;
      w_val_r     <= s3_val;
      out_data_r.status      <= s3_status_r;
      out_data_r.reg_written <= s3_rw_r;
      out_data_r.reg_index   <= s3_rw_r ? s3_dst_r : 5'd0;
      out_data_r.reg_value   <= s3_rw_r ? s3_val : 32'd0;
      out_data_r.mem_written <= s3_mw_r;
      out_data_r.mem_index   <= s3_midx_r;
      out_data_r.mem_value   <= s3_mval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r    <= '0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      w_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (s3_vld_r && s3_rw_r) begin
        rf_vld_r[s3_dst_r] <= 1'b1;
      end
      s2_vld_r    <= !q_empty;
      s3_vld_r    <= s2_vld_r;
      w_vld_r     <= s3_vld_r && s3_rw_r;
      out_valid_r <= s3_vld_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/mips_subset_execute_unit.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// input     in_valid, in_stall, in_data             valid high, stall low
// result    out_valid, out_stall, out_data          valid high, stall low
// config    cfg_valid, cfg_ready, cfg_data          valid and ready high
//
// One transaction per cycle is sustained while out_stall is low; an accepted
// input passes through the queue and the three register stages of the back end.
// Register and data memory results are forwarded, so dependent back-to-back
// transactions run without bubbles. Reset is synchronous and clears control
// state and the register file valid bits; no clearing pass is needed.
// A stalled result holds the back end while the queue keeps taking inputs
// until it holds four.

module mips_subset_execute_unit #(
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mse_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mse_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  logic          q_wr;
  logic          q_rd;
  logic          q_full;
  logic          q_empty;
  mse_pkg::dec_t q_wdata;
  mse_pkg::dec_t q_rdata;

  mse_front #(
    .DATA_WORDS(DATA_WORDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  mse_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (q_wr),
    .wdata(q_wdata),
    .full (q_full),
    .rd   (q_rd),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  mse_back #(
    .DATA_WORDS(DATA_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .q_rdata  (q_rdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.reg_written && out_data.reg_index == 5'd0))
    else $error("register zero reported as written");

  a_reg_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.reg_written) |->
      (out_data.reg_index == 5'd0 && out_data.reg_value == 32'sd0))
    else $error("register fields not cleared without a write");

  a_store_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.mem_written) |->
      (out_data.status == mse_pkg::ST_DONE && !out_data.reg_written))
    else $error("store reported with bad status or register write");

  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && q_empty) |=> !q_empty)
    else $error("accepted transaction lost in queue");

endmodule
